// File: design/line_edit_buffer_with_cursor_assert.svh
// assertion macros used by the line edit buffer checker
`ifndef LINE_EDIT_BUFFER_WITH_CURSOR_ASSERT_SVH
`define LINE_EDIT_BUFFER_WITH_CURSOR_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define LEBC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line edit buffer assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define LEBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line edit buffer assertion failed");

`endif

// File: design/lebc_pkg.sv
// types, constants and microcode program of the line edit buffer
package lebc_pkg;

   localparam logic [2:0] OP_HOME  = 3'd0;
   localparam logic [2:0] OP_END   = 3'd1;
   localparam logic [2:0] OP_LEFT  = 3'd2;
   localparam logic [2:0] OP_RIGHT = 3'd3;
   localparam logic [2:0] OP_TYPE  = 3'd4;
   localparam logic [2:0] OP_ERASE = 3'd5;
   localparam logic [2:0] OP_PRINT = 3'd6;

   localparam logic [7:0] KEY_LO      = 8'h20;
   localparam logic [7:0] KEY_HI      = 8'h7E;
   localparam logic [6:0] CURSOR_MARK = 7'h7C;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] key;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [6:0] char_out;
      logic       last;
   } rsp_type;

   typedef logic [4:0] step_type;

   localparam step_type S_IDLE    = 5'd0;
   localparam step_type S_HOME    = 5'd1;
   localparam step_type S_END     = 5'd2;
   localparam step_type S_LEFT    = 5'd3;
   localparam step_type S_RIGHT   = 5'd4;
   localparam step_type S_TYPE    = 5'd5;
   localparam step_type S_INS_RD  = 5'd6;
   localparam step_type S_INS_WR  = 5'd7;
   localparam step_type S_INS_PUT = 5'd8;
   localparam step_type S_FAIL    = 5'd9;
   localparam step_type S_ERASE   = 5'd10;
   localparam step_type S_DEL_RD  = 5'd11;
   localparam step_type S_DEL_WR  = 5'd12;
   localparam step_type S_DEL_FIN = 5'd13;
   localparam step_type S_PRINT   = 5'd14;
   localparam step_type S_PR_POS  = 5'd15;
   localparam step_type S_PR_CHR  = 5'd16;
   localparam step_type S_PR_MARK = 5'd17;

   typedef enum logic [2:0] {
      C_NEVER         = 3'd0,
      C_ALWAYS        = 3'd1,
      C_TYPE_BAD      = 3'd2,
      C_CURSOR_ZERO   = 3'd3,
      C_IDX_LE_CURSOR = 3'd4,
      C_IDX_GE_COUNT  = 3'd5,
      C_IDX_EQ_CURSOR = 3'd6,
      C_IDX_NE_COUNT  = 3'd7
   } cond_type;

   typedef enum logic [2:0] {
      IX_KEEP   = 3'd0,
      IX_ZERO   = 3'd1,
      IX_COUNT  = 3'd2,
      IX_CURSOR = 3'd3,
      IX_INC    = 3'd4,
      IX_DEC    = 3'd5
   } idx_op_type;

   typedef enum logic [2:0] {
      CU_KEEP  = 3'd0,
      CU_ZERO  = 3'd1,
      CU_COUNT = 3'd2,
      CU_INC   = 3'd3,
      CU_DEC   = 3'd4,
      CU_RIGHT = 3'd5
   } cur_op_type;

   typedef enum logic [1:0] {
      CN_KEEP = 2'd0,
      CN_INC  = 2'd1,
      CN_DEC  = 2'd2
   } cnt_op_type;

   typedef enum logic [1:0] {
      RD_NONE   = 2'd0,
      RD_IDX    = 2'd1,
      RD_IDX_M1 = 2'd2,
      RD_PRINT  = 2'd3
   } rd_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_UP   = 2'd1,
      WR_DOWN = 2'd2,
      WR_KEY  = 2'd3
   } wr_type;

   typedef enum logic [2:0] {
      EM_NONE = 3'd0,
      EM_OK   = 3'd1,
      EM_FAIL = 3'd2,
      EM_MARK = 3'd3,
      EM_CHAR = 3'd4
   } emit_type;

   typedef struct packed {
      cond_type   cond;
      step_type   target;
      idx_op_type idx_op;
      cur_op_type cur_op;
      cnt_op_type cnt_op;
      rd_type     rd;
      wr_type     wr;
      emit_type   emit;
      logic       last_if_end;
      logic       done;
   } cw_type;

   typedef struct packed {
      logic type_bad;
      logic cursor_zero;
      logic idx_le_cursor;
      logic idx_ge_count;
      logic idx_eq_cursor;
      logic idx_ne_count;
      logic slot_free;
   } status_type;

   function automatic step_type entry(input logic [2:0] op);
      step_type s;
      unique case (op)
         OP_HOME:  s = S_HOME;
         OP_END:   s = S_END;
         OP_LEFT:  s = S_LEFT;
         OP_RIGHT: s = S_RIGHT;
         OP_TYPE:  s = S_TYPE;
         OP_ERASE: s = S_ERASE;
         OP_PRINT: s = S_PRINT;
         default:  s = S_FAIL;
      endcase
      return s;
   endfunction

   function automatic cw_type ucode(input step_type step);
      cw_type cw;
      cw = '0;
      case (step)
         S_HOME: begin
            cw.cur_op = CU_ZERO;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_END: begin
            cw.cur_op = CU_COUNT;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_LEFT: begin
            cw.cur_op = CU_DEC;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_RIGHT: begin
            cw.cur_op = CU_RIGHT;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_TYPE: begin
            cw.cond   = C_TYPE_BAD;
            cw.target = S_FAIL;
            cw.idx_op = IX_COUNT;
         end
         S_INS_RD: begin
            cw.cond   = C_IDX_LE_CURSOR;
            cw.target = S_INS_PUT;
            cw.rd     = RD_IDX_M1;
         end
         S_INS_WR: begin
            cw.cond   = C_ALWAYS;
            cw.target = S_INS_RD;
            cw.wr     = WR_UP;
            cw.idx_op = IX_DEC;
         end
         S_INS_PUT: begin
            cw.wr     = WR_KEY;
            cw.cnt_op = CN_INC;
            cw.cur_op = CU_INC;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_FAIL: begin
            cw.emit = EM_FAIL;
            cw.done = 1'b1;
         end
         S_ERASE: begin
            cw.cond   = C_CURSOR_ZERO;
            cw.target = S_FAIL;
            cw.idx_op = IX_CURSOR;
         end
         S_DEL_RD: begin
            cw.cond   = C_IDX_GE_COUNT;
            cw.target = S_DEL_FIN;
            cw.rd     = RD_IDX;
         end
         S_DEL_WR: begin
            cw.cond   = C_ALWAYS;
            cw.target = S_DEL_RD;
            cw.wr     = WR_DOWN;
            cw.idx_op = IX_INC;
         end
         S_DEL_FIN: begin
            cw.cnt_op = CN_DEC;
            cw.cur_op = CU_DEC;
            cw.emit   = EM_OK;
            cw.done   = 1'b1;
         end
         S_PRINT: begin
            cw.idx_op = IX_ZERO;
         end
         S_PR_POS: begin
            cw.cond   = C_IDX_EQ_CURSOR;
            cw.target = S_PR_MARK;
            cw.rd     = RD_PRINT;
         end
         S_PR_CHR: begin
            cw.cond        = C_IDX_NE_COUNT;
            cw.target      = S_PR_POS;
            cw.emit        = EM_CHAR;
            cw.last_if_end = 1'b1;
            cw.idx_op      = IX_INC;
            cw.done        = 1'b1;
         end
         S_PR_MARK: begin
            cw.cond        = C_IDX_NE_COUNT;
            cw.target      = S_PR_POS;
            cw.emit        = EM_MARK;
            cw.last_if_end = 1'b1;
            cw.idx_op      = IX_INC;
            cw.done        = 1'b1;
         end
         default: begin
            cw.done = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: design/lebc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module lebc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lebc_seq.sv
// microcode sequencer: step counter, control rom and jump conditions
module lebc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_op,
   output logic                 req_ready,
   input  lebc_pkg::status_type status,
   output lebc_pkg::cw_type     ctl
);

   lebc_pkg::step_type step_ff;
   lebc_pkg::step_type step_in;
   lebc_pkg::cw_type   cw;
   logic               busy;
   logic               go;
   logic               taken;

   always_comb begin
      cw   = lebc_pkg::ucode(step_ff);
      busy = (step_ff != lebc_pkg::S_IDLE);
      go   = busy && ((cw.emit == lebc_pkg::EM_NONE) || status.slot_free);

      case (cw.cond)
         lebc_pkg::C_NEVER:         taken = 1'b0;
         lebc_pkg::C_ALWAYS:        taken = 1'b1;
         lebc_pkg::C_TYPE_BAD:      taken = status.type_bad;
         lebc_pkg::C_CURSOR_ZERO:   taken = status.cursor_zero;
         lebc_pkg::C_IDX_LE_CURSOR: taken = status.idx_le_cursor;
         lebc_pkg::C_IDX_GE_COUNT:  taken = status.idx_ge_count;
         lebc_pkg::C_IDX_EQ_CURSOR: taken = status.idx_eq_cursor;
         lebc_pkg::C_IDX_NE_COUNT:  taken = status.idx_ne_count;
         default:                   taken = 1'b0;
      endcase

      step_in = step_ff;
      if (!busy) begin
         if (req_valid) begin
            step_in = lebc_pkg::entry(req_op);
         end
      end else if (go) begin
         if (taken) begin
            step_in = cw.target;
         end else if (cw.done) begin
            step_in = lebc_pkg::S_IDLE;
         end else begin
            step_in = step_ff + 5'd1;
         end
      end

      ctl = go ? cw : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lebc_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_ready = !busy;

endmodule

// File: design/lebc_dp.sv
// datapath: count, cursor and index registers, text store and result register
module lebc_dp #(
   parameter int MAX_CHARS = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 key_load,
   input  logic [7:0]           key,
   input  lebc_pkg::cw_type     ctl,
   output lebc_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lebc_pkg::rsp_type    rsp_payload
);

   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam logic [CW-1:0] FULL = CW'(MAX_CHARS);

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [7:0]        key_ff;
   lebc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] idx_m1;
   logic [CW-1:0] rd_pos;
   logic [CW-1:0] wr_pos;
   logic          rd_en;
   logic          wr_en;
   logic [6:0]    wr_data;
   logic [6:0]    rd_data;
   logic          emit;

   lebc_ram #(
      .WIDTH(7),
      .DEPTH(MAX_CHARS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_pos[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_pos[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      status.type_bad      = (key_ff < lebc_pkg::KEY_LO) || (key_ff > lebc_pkg::KEY_HI) ||
                             (count_ff >= FULL);
      status.cursor_zero   = (cursor_ff == '0);
      status.idx_le_cursor = (idx_ff <= cursor_ff);
      status.idx_ge_count  = (idx_ff >= count_ff);
      status.idx_eq_cursor = (idx_ff == cursor_ff);
      status.idx_ne_count  = (idx_ff != count_ff);
      status.slot_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      idx_m1 = idx_ff - CW'(1);

      rd_en  = (ctl.rd != lebc_pkg::RD_NONE);
      case (ctl.rd)
         lebc_pkg::RD_IDX:    rd_pos = idx_ff;
         lebc_pkg::RD_IDX_M1: rd_pos = idx_m1;
         lebc_pkg::RD_PRINT:  rd_pos = (idx_ff < cursor_ff) ? idx_ff : idx_m1;
         default:             rd_pos = idx_ff;
      endcase

      wr_en = (ctl.wr != lebc_pkg::WR_NONE);
      case (ctl.wr)
         lebc_pkg::WR_UP: begin
            wr_pos  = idx_ff;
            wr_data = rd_data;
         end
         lebc_pkg::WR_DOWN: begin
            wr_pos  = idx_m1;
            wr_data = rd_data;
         end
         lebc_pkg::WR_KEY: begin
            wr_pos  = cursor_ff;
            wr_data = key_ff[6:0];
         end
         default: begin
            wr_pos  = idx_ff;
            wr_data = rd_data;
         end
      endcase

      case (ctl.idx_op)
         lebc_pkg::IX_ZERO:   idx_in = '0;
         lebc_pkg::IX_COUNT:  idx_in = count_ff;
         lebc_pkg::IX_CURSOR: idx_in = cursor_ff;
         lebc_pkg::IX_INC:    idx_in = idx_ff + CW'(1);
         lebc_pkg::IX_DEC:    idx_in = idx_m1;
         default:             idx_in = idx_ff;
      endcase

      cursor_in = cursor_ff;
      case (ctl.cur_op)
         lebc_pkg::CU_ZERO:  cursor_in = '0;
         lebc_pkg::CU_COUNT: cursor_in = count_ff;
         lebc_pkg::CU_INC:   cursor_in = cursor_ff + CW'(1);
         lebc_pkg::CU_DEC: begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - CW'(1);
            end
         end
         lebc_pkg::CU_RIGHT: begin
            if (cursor_ff < count_ff) begin
               cursor_in = cursor_ff + CW'(1);
            end
         end
         default: cursor_in = cursor_ff;
      endcase

      case (ctl.cnt_op)
         lebc_pkg::CN_INC: count_in = count_ff + CW'(1);
         lebc_pkg::CN_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase

      emit = (ctl.emit != lebc_pkg::EM_NONE);
      rsp_in.accepted = (ctl.emit != lebc_pkg::EM_FAIL);
      case (ctl.emit)
         lebc_pkg::EM_MARK: rsp_in.char_out = lebc_pkg::CURSOR_MARK;
         lebc_pkg::EM_CHAR: rsp_in.char_out = rd_data;
         default:           rsp_in.char_out = '0;
      endcase
      rsp_in.last = ctl.last_if_end ? (idx_ff == count_ff) : 1'b1;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_load) begin
         key_ff <= key;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/line_edit_buffer_with_cursor.sv
// line edit buffer top level: microcode sequencer driving the text datapath
// home, end, left, right, unknown op: a single microcode step that emits the result
// rejected type and erase: the check step, then the fail step that emits the rejection
// type, erase: read and write step per char after cursor; print: pos and emit step per output
// one transaction in flight; emitting steps wait while a held result is not taken by rsp_ready
// reset clears count, cursor and result valid; store contents stay undefined, no clearing pass
module line_edit_buffer_with_cursor #(
   parameter int MAX_CHARS = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lebc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lebc_pkg::rsp_type rsp_payload
);

   lebc_pkg::cw_type     ctl;
   lebc_pkg::status_type status;
   logic                 req_accept;

   assign req_accept = req_valid && req_ready;

   lebc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_payload.operation),
      .req_ready(req_ready),
      .status   (status),
      .ctl      (ctl)
   );

   lebc_dp #(
      .MAX_CHARS(MAX_CHARS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .key_load   (req_accept),
      .key        (req_payload.key),
      .ctl        (ctl),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// File: design/lebc_checker.sv
// port-level checker for the line edit buffer and its bind
`include "line_edit_buffer_with_cursor_assert.svh"

module lebc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input lebc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lebc_pkg::rsp_type rsp_payload
);

   `LEBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `LEBC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   `LEBC_ASSERT_SAME(a_mid_print_ok, rsp_valid && !rsp_payload.last, rsp_payload.accepted)
   `LEBC_ASSERT_SAME(a_status_is_last, rsp_valid && (rsp_payload.char_out == 7'd0), rsp_payload.last)

endmodule

bind line_edit_buffer_with_cursor lebc_checker u_checker (.*);
